// ===== sv/twist_pkg.sv =====
package twist_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int FRAC_BITS_DEF     = 16;

	// pi with 62 fraction bits
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

	// Angle constants and CORDIC gain in Q30
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
	} point_t;

	typedef struct packed {
		logic signed [31:0] out_point_x;
		logic signed [31:0] out_point_y;
		logic signed [31:0] out_point_z;
		logic signed [31:0] out_normal_x;
		logic signed [31:0] out_normal_y;
		logic signed [31:0] out_normal_z;
	} result_t;

	// two pi rounded to 2*frac fraction bits
	function automatic logic [63:0] two_pi_q(input int frac);
		int sh2;
		sh2 = 61 - 2 * frac;
		return (PI_Q62 + (64'd1 << (sh2 - 1))) >> sh2;
	endfunction

	// arctan(2^-n) in Q30
	function automatic logic [31:0] atan_q30(input int n);
		logic [31:0] v;
		case (n)
			0:  v = 32'd843314857;
			1:  v = 32'd497837829;
			2:  v = 32'd263043837;
			3:  v = 32'd133525159;
			4:  v = 32'd67021687;
			5:  v = 32'd33543516;
			6:  v = 32'd16775851;
			7:  v = 32'd8388437;
			8:  v = 32'd4194283;
			9:  v = 32'd2097149;
			10: v = 32'd1048576;
			11: v = 32'd524288;
			12: v = 32'd262144;
			13: v = 32'd131072;
			14: v = 32'd65536;
			15: v = 32'd32768;
			16: v = 32'd16384;
			17: v = 32'd8192;
			18: v = 32'd4096;
			19: v = 32'd2048;
			20: v = 32'd1024;
			21: v = 32'd512;
			22: v = 32'd256;
			23: v = 32'd128;
			24: v = 32'd64;
			25: v = 32'd32;
			26: v = 32'd16;
			27: v = 32'd8;
			28: v = 32'd4;
			29: v = 32'd2;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/twist_deform_point_normal.sv =====
// Twist deformation of a point and its normal about z, Q16.16 in and out.
// One request is taken every cycle unless the pipeline is held. The pipeline has
// 1 product stage + (61 - 2*FRAC_BITS) angle-reduction stages (one compare and
// subtract of 2*pi each) + 1 fold stage + CORDIC_STAGES CORDIC stages + 1
// multiply stage + 1 output stage. The whole pipeline holds while the output
// register is full and stalled. twist_rate is written through cfg_we/cfg_data
// and should only change while the pipe is empty.
module twist_deform_point_normal #(
	parameter int CORDIC_STAGES = twist_pkg::CORDIC_STAGES_DEF,
	parameter int FRAC_BITS     = twist_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_data,
	input  logic                point_valid,
	output logic                point_stall,
	input  twist_pkg::point_t   point,
	output logic                result_valid,
	input  logic                result_stall,
	output twist_pkg::result_t  result
);

	localparam logic [63:0] TW_PI = twist_pkg::two_pi_q(FRAC_BITS);
	localparam int QB  = 64 - (2 * FRAC_BITS + 3);
	localparam int SH  = 2 * FRAC_BITS - 30;
	localparam int SHR = (SH > 0) ? SH : 0;
	localparam int SHL = (SH < 0) ? -SH : 0;
	localparam logic [63:0] RND = (SH > 0) ? (64'd1 << (SHR - 1)) : 64'd0;
	localparam logic signed [67:0] FRND = 68'sd1 <<< (FRAC_BITS - 1);

	typedef struct packed {
		twist_pkg::point_t  pt;
		logic signed [63:0] pxk;
		logic signed [63:0] pyk;
	} red_side_t;

	typedef struct packed {
		twist_pkg::point_t  pt;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
	} cor_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -68'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	logic               adv;
	logic signed [31:0] rate_q;

	assign adv         = !result_valid || !result_stall;
	assign point_stall = !adv;

	// Write the twist rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rate_q <= '0;
		else if (cfg_we)
			rate_q <= cfg_data;
	end

	// Stage 1: angle product and shear products
	logic               v_s1;
	logic signed [63:0] prod_s1;
	red_side_t          side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= point_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1     <= 64'(rate_q * point.point_z);
			side_s1.pt  <= point;
			side_s1.pxk <= 64'(point.point_x * rate_q);
			side_s1.pyk <= 64'(point.point_y * rate_q);
		end
	end

	// Reduce |product| modulo two pi, one quotient bit per stage
	logic        red_v    [QB];
	logic [63:0] red_rem  [QB];
	logic        red_neg  [QB];
	red_side_t   red_side [QB];

	logic [63:0] abs_s1;
	assign abs_s1 = prod_s1[63] ? 64'(-prod_s1) : 64'(prod_s1);

	for (genvar g = 0; g < QB; g++) begin : g_red
		localparam logic [63:0] SUB = TW_PI << (QB - 1 - g);
		logic        vin;
		logic [63:0] rin;
		logic        nin;
		red_side_t   sin;
		if (g == 0) begin : g_first
			assign vin = v_s1;
			assign rin = abs_s1;
			assign nin = prod_s1[63];
			assign sin = side_s1;
		end else begin : g_next
			assign vin = red_v[g-1];
			assign rin = red_rem[g-1];
			assign nin = red_neg[g-1];
			assign sin = red_side[g-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				red_v[g] <= 1'b0;
			else if (adv)
				red_v[g] <= vin;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				red_rem[g]  <= (rin >= SUB) ? rin - SUB : rin;
				red_neg[g]  <= nin;
				red_side[g] <= sin;
			end
		end
	end

	// Fold: wrap to [0, 2pi), round to Q30, fold to [-pi/2, pi/2]; shear factors
	logic               fx_v;
	logic [63:0]        fx_r;
	logic [63:0]        fx_afull;
	logic signed [35:0] fx_a0;
	logic signed [35:0] fx_a1;
	logic signed [35:0] fx_a;
	logic               fx_flip;
	logic signed [63:0] fx_yr;
	logic signed [63:0] fx_xr;

	always_comb begin
		fx_r     = (red_neg[QB-1] && red_rem[QB-1] != '0) ? TW_PI - red_rem[QB-1]
			: red_rem[QB-1];
		fx_afull = ((fx_r + RND) >> SHR) << SHL;
		fx_a0    = $signed({1'b0, fx_afull[34:0]});
		fx_a1    = (fx_a0 > twist_pkg::PI_Q30) ? fx_a0 - twist_pkg::TWO_PI_Q30 : fx_a0;
		fx_flip  = 1'b0;
		fx_a     = fx_a1;
		if (fx_a1 > twist_pkg::HALF_PI_Q30) begin
			fx_a    = fx_a1 - twist_pkg::PI_Q30;
			fx_flip = 1'b1;
		end else if (fx_a1 < -twist_pkg::HALF_PI_Q30) begin
			fx_a    = fx_a1 + twist_pkg::PI_Q30;
			fx_flip = 1'b1;
		end
		fx_yr = (red_side[QB-1].pyk + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		fx_xr = (red_side[QB-1].pxk + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	end

	logic               v_s2;
	logic signed [35:0] ang_s2;
	logic               flip_s2;
	cor_side_t          side_s2;

	assign fx_v = red_v[QB-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= fx_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s2     <= fx_a;
			flip_s2    <= fx_flip;
			side_s2.pt <= red_side[QB-1].pt;
			side_s2.ay <= sat32(68'(fx_yr));
			side_s2.bx <= sat32(68'(fx_xr));
		end
	end

	// CORDIC rotation, one micro-rotation per stage
	logic               cv    [CORDIC_STAGES];
	logic signed [33:0] cx    [CORDIC_STAGES];
	logic signed [33:0] cy    [CORDIC_STAGES];
	logic signed [35:0] ca    [CORDIC_STAGES];
	logic               cflip [CORDIC_STAGES];
	cor_side_t          cside [CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
		localparam logic signed [35:0] ATN = $signed({4'd0, twist_pkg::atan_q30(i)});
		logic               vin;
		logic signed [33:0] xin;
		logic signed [33:0] yin;
		logic signed [35:0] ain;
		logic               fin;
		cor_side_t          sin;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		if (i == 0) begin : g_first
			assign vin = v_s2;
			assign xin = twist_pkg::GAIN_Q30;
			assign yin = '0;
			assign ain = ang_s2;
			assign fin = flip_s2;
			assign sin = side_s2;
		end else begin : g_next
			assign vin = cv[i-1];
			assign xin = cx[i-1];
			assign yin = cy[i-1];
			assign ain = ca[i-1];
			assign fin = cflip[i-1];
			assign sin = cside[i-1];
		end
		assign dx = yin >>> i;
		assign dy = xin >>> i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv[i] <= 1'b0;
			else if (adv)
				cv[i] <= vin;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!ain[35]) begin
					cx[i] <= xin - dx;
					cy[i] <= yin + dy;
					ca[i] <= ain - ATN;
				end else begin
					cx[i] <= xin + dx;
					cy[i] <= yin - dy;
					ca[i] <= ain + ATN;
				end
				cflip[i] <= fin;
				cside[i] <= sin;
			end
		end
	end

	// Multiply stage: rotation and shear products
	logic signed [33:0] cos_c;
	logic signed [33:0] sin_c;
	cor_side_t          lside;

	assign lside = cside[CORDIC_STAGES-1];
	assign cos_c = cflip[CORDIC_STAGES-1] ? -cx[CORDIC_STAGES-1] : cx[CORDIC_STAGES-1];
	assign sin_c = cflip[CORDIC_STAGES-1] ? -cy[CORDIC_STAGES-1] : cy[CORDIC_STAGES-1];

	logic               v_s3;
	logic signed [65:0] pxc_s3, pys_s3, pyc_s3, pxs_s3;
	logic signed [65:0] nxc_s3, nys_s3, nxs_s3, nyc_s3;
	logic signed [63:0] ayn_s3, bxn_s3;
	logic signed [31:0] pz_s3, nz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= cv[CORDIC_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxc_s3 <= 66'(lside.pt.point_x * cos_c);
			pys_s3 <= 66'(lside.pt.point_y * sin_c);
			pyc_s3 <= 66'(lside.pt.point_y * cos_c);
			pxs_s3 <= 66'(lside.pt.point_x * sin_c);
			nxc_s3 <= 66'(lside.pt.normal_x * cos_c);
			nys_s3 <= 66'(lside.pt.normal_y * sin_c);
			nxs_s3 <= 66'(lside.pt.normal_x * sin_c);
			nyc_s3 <= 66'(lside.pt.normal_y * cos_c);
			ayn_s3 <= 64'(lside.ay * lside.pt.normal_x);
			bxn_s3 <= 64'(lside.bx * lside.pt.normal_y);
			pz_s3  <= lside.pt.point_z;
			nz_s3  <= lside.pt.normal_z;
		end
	end

	// Output stage: sum, round half up, saturate
	logic signed [67:0] o_px, o_py, o_nx, o_ny, o_sh, o_nz;
	localparam logic signed [67:0] HALF30 = 68'sd1 <<< 29;

	always_comb begin
		o_px = (68'(pxc_s3) + 68'(pys_s3) + HALF30) >>> 30;
		o_py = (68'(pyc_s3) - 68'(pxs_s3) + HALF30) >>> 30;
		o_nx = (68'(nxc_s3) - 68'(nys_s3) + HALF30) >>> 30;
		o_ny = (68'(nxs_s3) + 68'(nyc_s3) + HALF30) >>> 30;
		o_sh = (68'(ayn_s3) - 68'(bxn_s3) + FRND) >>> FRAC_BITS;
		o_nz = o_sh + 68'(nz_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (adv)
			result_valid <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.out_point_x  <= sat32(o_px);
			result.out_point_y  <= sat32(o_py);
			result.out_point_z  <= pz_s3;
			result.out_normal_x <= sat32(o_nx);
			result.out_normal_y <= sat32(o_ny);
			result.out_normal_z <= sat32(o_nz);
		end
	end

endmodule

// ===== dv/twist_deform_point_normal_tb.sv =====
module twist_deform_point_normal_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = twist_pkg::FRAC_BITS_DEF;
	localparam int STAGES = twist_pkg::CORDIC_STAGES_DEF;
	localparam int PIPE_DRAIN = 80;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int LONG_HOLD = 400;
	localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
	localparam logic signed [31:0] MINV = 32'sh80000000;
	localparam logic signed [31:0] ONE = 32'sh00010000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_data = '0;
	logic point_valid = 1'b0;
	logic point_stall;
	twist_pkg::point_t point = '0;
	logic result_valid;
	logic result_stall = 1'b1;
	twist_pkg::result_t result;

	// predictor copy of the twist rate register
	logic signed [31:0] rate_shadow = '0;
	twist_pkg::result_t deformed_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit long_hold_req = 0;

	typedef struct {
		logic signed [31:0] rate;
		twist_pkg::point_t pt;
		bit known;
		logic signed [31:0] exp_pz;
		logic signed [31:0] exp_nz;
	} vector_t;

	always #6 clk = ~clk;

	twist_deform_point_normal i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// arctangent table, Q30
	function automatic longint atan_q30_val(int n);
		longint tbl[31] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		return (n < 31) ? tbl[n] : 0;
	endfunction

	// compute the deformed point and normal for one request
	function automatic twist_pkg::result_t deform(twist_pkg::point_t p,
		logic signed [31:0] k);
		logic [63:0] tp_u;
		longint two_pi, prod, r, a, x, y, t, c, s;
		longint px, py, pz, nx, ny, nz, kk, ay, bx;
		bit flip;
		twist_pkg::result_t res;
		tp_u = (twist_pkg::PI_Q62 + (64'd1 << (60 - 2 * FRAC))) >> (61 - 2 * FRAC);
		two_pi = longint'(tp_u);
		px = p.point_x; py = p.point_y; pz = p.point_z;
		nx = p.normal_x; ny = p.normal_y; nz = p.normal_z;
		kk = k;
		prod = kk * pz;
		r = prod % two_pi;
		if (r < 0) r += two_pi;
		a = (r + (64'sd1 <<< (2 * FRAC - 31))) >>> (2 * FRAC - 30);
		// fold into [-pi/2, pi/2]
		if (a > longint'(twist_pkg::PI_Q30)) a -= longint'(twist_pkg::TWO_PI_Q30);
		flip = 0;
		if (a > longint'(twist_pkg::HALF_PI_Q30)) begin
			a -= longint'(twist_pkg::PI_Q30);
			flip = 1;
		end else if (a < -longint'(twist_pkg::HALF_PI_Q30)) begin
			a += longint'(twist_pkg::PI_Q30);
			flip = 1;
		end
		x = longint'(twist_pkg::GAIN_Q30);
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			if (a >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				a -= longint'(atan_q30_val(i));
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				a += longint'(atan_q30_val(i));
			end
			x = t;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		res.out_point_x = 32'(sat32(round_shift(px * c + py * s, 30)));
		res.out_point_y = 32'(sat32(round_shift(py * c - px * s, 30)));
		res.out_point_z = p.point_z;
		res.out_normal_x = 32'(sat32(round_shift(nx * c - ny * s, 30)));
		res.out_normal_y = 32'(sat32(round_shift(nx * s + ny * c, 30)));
		ay = sat32(round_shift(py * kk, FRAC));
		bx = sat32(round_shift(px * kk, FRAC));
		res.out_normal_z = 32'(sat32(round_shift(ay * nx - bx * ny, FRAC) + nz));
		return res;
	endfunction

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(0, 6))
			0: return MAXV;
			1: return MINV;
			2: return '0;
			3: return 32'($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
			4: return 32'($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
			default: return $urandom;
		endcase
	endfunction

	function automatic twist_pkg::point_t random_point();
		twist_pkg::point_t p;
		p.point_x = pick_coord();
		p.point_y = pick_coord();
		p.point_z = pick_coord();
		p.normal_x = pick_coord();
		p.normal_y = pick_coord();
		p.normal_z = pick_coord();
		return p;
	endfunction

	function automatic twist_pkg::point_t mk(logic signed [31:0] px, py, pz, nx, ny, nz);
		twist_pkg::point_t p;
		p = '{px, py, pz, nx, ny, nz};
		return p;
	endfunction

	// drop the request, wait for the pipe to empty, then write the twist rate
	task automatic write_rate(logic signed [31:0] k);
		point_valid <= 1'b0;
		while (deformed_q.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate_shadow = k;
	endtask

	// offer one request after a random gap and hold it until taken
	task automatic send_point(twist_pkg::point_t p, twist_pkg::result_t exp_res);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		point <= p;
		@(posedge clk);
		while (!(point_valid && !point_stall)) @(posedge clk);
		deformed_q.push_back(exp_res);
	endtask

	// stimulus
	initial begin
		vector_t vecs[$];
		vector_t v;
		twist_pkg::result_t er;
		logic signed [31:0] rates[$];
		twist_pkg::point_t p;
		int n;
		vecs.push_back('{32'sd0, mk(0, 0, 0, 0, 0, 0), 1, 32'sd0, 32'sd0});
		vecs.push_back('{32'sd0, mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 1, MAXV, MAXV});
		vecs.push_back('{32'sd0, mk(MINV, MINV, MINV, MINV, MINV, MINV), 1, MINV, MINV});
		vecs.push_back('{32'sd0, mk(MAXV, MINV, MAXV, MINV, MAXV, MINV), 1, MAXV, MINV});
		vecs.push_back('{32'sd0, mk(ONE, -ONE, ONE, ONE, -ONE, ONE), 1, ONE, ONE});
		vecs.push_back('{ONE, mk(ONE, 0, 0, ONE, 0, 0), 0, 0, 0});
		vecs.push_back('{ONE, mk(ONE, ONE, ONE, ONE, ONE, ONE), 0, 0, 0});
		vecs.push_back('{ONE, mk(MAXV, MAXV, 32'sh00032000, MAXV, MAXV, MAXV), 0, 0, 0});
		vecs.push_back('{ONE, mk(MINV, MINV, 32'sh0001921F, MINV, MINV, MINV), 0, 0, 0});
		vecs.push_back('{ONE, mk(ONE, -ONE, -32'sh0001921F, MAXV, MINV, MAXV), 0, 0, 0});
		vecs.push_back('{MAXV, mk(MAXV, MINV, MAXV, MAXV, MINV, MINV), 0, 0, 0});
		vecs.push_back('{MAXV, mk(MINV, MAXV, MINV, MINV, MAXV, MAXV), 0, 0, 0});
		vecs.push_back('{MAXV, mk(ONE, ONE, MINV, MAXV, MAXV, 0), 0, 0, 0});
		vecs.push_back('{MINV, mk(MINV, MINV, MINV, MINV, MINV, MINV), 0, 0, 0});
		vecs.push_back('{MINV, mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 0, 0, 0});
		vecs.push_back('{MINV, mk(MAXV, MINV, 32'sd1, MINV, MAXV, MAXV), 0, 0, 0});
		vecs.push_back('{-ONE, mk(ONE, 2 * ONE, 3 * ONE, -ONE, ONE, ONE), 0, 0, 0});
		vecs.push_back('{-ONE, mk(-ONE, -ONE, -32'sh00032440, ONE, ONE, -ONE), 0, 0, 0});
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (vecs[i]) begin
			v = vecs[i];
			if (v.rate !== rate_shadow) write_rate(v.rate);
			er = deform(v.pt, rate_shadow);
			if (v.known) begin
				er.out_point_z = v.exp_pz;
				er.out_normal_z = v.exp_nz;
			end
			send_point(v.pt, er);
		end

		// random phases over several twist rates
		rates = '{ONE, MAXV, MINV, 32'($urandom), 32'sh00000001, 32'shFFFF0000,
			32'($urandom_range(0, 32'h3FFFF)) - 32'sh20000};
		foreach (rates[r]) begin
			write_rate(rates[r]);
			if (r == 2) long_hold_req = 1;
			n = 264;
			repeat (n) begin
				p = random_point();
				send_point(p, deform(p, rate_shadow));
			end
		end
		point_valid <= 1'b0;
		while (deformed_q.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// result sink with random and long hold-offs
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (long_hold_req) begin
				n = LONG_HOLD;
				long_hold_req = 0;
			end
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!(result_valid && !result_stall)) @(posedge clk);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		twist_pkg::result_t want;
		logic [5:0][31:0] w, g;
		bit bad;
		if (arst_n && result_valid && !result_stall) begin
			if (deformed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				want = deformed_q.pop_front();
				w = want;
				g = result;
				bad = 0;
				for (int f = 0; f < 6; f++)
					if (w[f] !== g[f]) bad = 1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						for (int f = 5; f >= 0; f--)
							if (w[f] !== g[f])
								$display("field %0d: expected %h got %h", 5 - f, w[f], g[f]);
					end
				end
			end
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((point_valid && !point_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
